[hw/rtl/sve_pkg.sv]
`timescale 1ns / 1ps
package sve_pkg;
   localparam int FACES_DEF = 1024;
   localparam int COORD_W = 32;
   localparam int OUT_W = 34;
   localparam int FACE_W = 10;

   localparam logic [2:0] MODE_CORNER = 3'd0;
   localparam logic [2:0] MODE_NORMAL = 3'd1;
   localparam logic [2:0] MODE_CENTER = 3'd2;
   localparam logic [2:0] MODE_NEIGHBOR = 3'd3;
   localparam logic [2:0] MODE_CLASSIFY = 3'd4;
   localparam logic [2:0] MODE_EMIT = 3'd5;

   localparam logic [1:0] CSR_LIGHT_X = 2'd0;
   localparam logic [1:0] CSR_LIGHT_Y = 2'd1;
   localparam logic [1:0] CSR_LIGHT_Z = 2'd2;

   // multiply-accumulate step command from the sequencer
   typedef struct packed {
      logic clear;
      logic enable;
      logic signed [31:0] a;
      logic signed [33:0] b;
   } mac_cmd_type;
endpackage

[hw/rtl/sve_mac.sv]
`timescale 1ns / 1ps
// shared signed multiply-accumulate, one 32x34 product per cycle
module sve_mac (
   input  logic clock,
   input  logic reset,
   input  sve_pkg::mac_cmd_type cmd,
   output logic signed [67:0] acc
);
   logic signed [67:0] acc_ff, acc_in;
   logic signed [65:0] prod;

   assign prod = cmd.a * cmd.b;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear) begin
         acc_in = '0;
      end else if (cmd.enable) begin
         acc_in = acc_ff + 68'(prod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;
endmodule

[hw/rtl/shadow_volume_extruder_top.sv]
`timescale 1ns / 1ps
// Shadow volume extruder. Load words (corner, normal, center, neighbor) are
// written in their accept cycle. A classify word is accepted, then does one
// memory read, three steps of a shared multiply-accumulate that sums
// normal . (center - light) exactly, then stores the sign. An emit word is
// accepted, reads the face's own away flag, its corners and neighbor links,
// then the three neighbors' away flags, decides, then streams 0 or 6..24
// vertices, one per cycle when rsp_tready is high; the output port of the
// vertex stream sets that rate. req_tready is low while a word is in work.
// Stores are not cleared at reset; reading an unwritten entry gives
// arbitrary data.
module shadow_volume_extruder_top #(
   parameter int FACES = sve_pkg::FACES_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // mode[2:0], face[12:3], corner[14:13], x[46:15], y[78:47], z[110:79],
   // neighbor[120:111], has_neighbor[121], zero pad to 128
   input  logic [127:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_x[33:0], out_y[67:34], out_z[101:68], w[102], zero pad to 104
   output logic [103:0] rsp_tdata,
   output logic rsp_tlast,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int CI_W = $clog2(3 * FACES);
   localparam int FI_W = (FACES > 1) ? $clog2(FACES) : 1;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_CRD  = 9'b000000010,
      S_DOT  = 9'b000000100,
      S_SIGN = 9'b000001000,
      S_LRD  = 9'b000010000,
      S_ARD  = 9'b000100000,
      S_CHK  = 9'b001000000,
      S_OUT  = 9'b010000000,
      S_AWAY = 9'b100000000
   } state_type;

   logic [2:0] in_mode;
   logic [9:0] in_face, in_nb;
   logic [1:0] in_corner;
   logic signed [31:0] in_v [3];
   logic in_hasnb;
   assign in_mode = req_tdata[2:0];
   assign in_face = req_tdata[12:3];
   assign in_corner = req_tdata[14:13];
   assign in_v[0] = req_tdata[46:15];
   assign in_v[1] = req_tdata[78:47];
   assign in_v[2] = req_tdata[110:79];
   assign in_nb = req_tdata[120:111];
   assign in_hasnb = req_tdata[121];

   logic signed [31:0] light_ff [3];

   // memories
   logic [95:0] corner_mem [3*FACES];
   logic [95:0] normal_mem [FACES];
   logic [95:0] center_mem [FACES];
   logic [10:0] nb_mem [3*FACES];
   logic away_mem [FACES];

   state_type state_ff, state_in;
   logic [FI_W-1:0] face_ff, face_in;
   logic [2:0] step_ff, step_in;
   logic [4:0] vtx_ff, vtx_in;
   logic [95:0] crd_rd, nrm_rd, ctr_rd, corner_rd;
   logic [10:0] nb_rd;
   logic away_rd;
   logic [95:0] crn_ff [3];
   logic [10:0] nbl_ff [3];
   logic [2:0] sil_ff;
   logic [CI_W-1:0] crd_addr;
   logic [FI_W-1:0] away_addr;

   logic in_ok, accept;
   assign in_ok = {22'd0, in_face} < 32'(FACES);
   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   localparam logic [1:0] CSR_LIGHT_X_SEL = sve_pkg::CSR_LIGHT_X;
   localparam logic [1:0] CSR_LIGHT_Y_SEL = sve_pkg::CSR_LIGHT_Y;
   localparam logic [1:0] CSR_LIGHT_Z_SEL = sve_pkg::CSR_LIGHT_Z;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff[0] <= '0;
         light_ff[1] <= '0;
         light_ff[2] <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHT_X_SEL: light_ff[0] <= csr_wdata;
            CSR_LIGHT_Y_SEL: light_ff[1] <= csr_wdata;
            CSR_LIGHT_Z_SEL: light_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [FI_W-1:0] fidx;
   logic [CI_W-1:0] widx;
   assign fidx = in_face[FI_W-1:0];
   assign widx = CI_W'({fidx, 2'b00} - {2'b00, fidx}) + CI_W'(in_corner);

   // corner read address: face base plus step; output takes corners from the crn_ff copies
   assign crd_addr = CI_W'({face_ff, 2'b00} - {2'b00, face_ff}) + CI_W'(step_ff);
   assign away_addr = (step_ff < 3'd3) ? nbl_ff[step_ff[1:0]][FI_W-1:0] : face_ff;

   always_ff @(posedge clock) begin
      if (accept && in_ok) begin
         if (in_mode == sve_pkg::MODE_CORNER && in_corner != 2'd3)
            corner_mem[widx] <= {in_v[2], in_v[1], in_v[0]};
         if (in_mode == sve_pkg::MODE_NORMAL)
            normal_mem[fidx] <= {in_v[2], in_v[1], in_v[0]};
         if (in_mode == sve_pkg::MODE_CENTER)
            center_mem[fidx] <= {in_v[2], in_v[1], in_v[0]};
         if (in_mode == sve_pkg::MODE_NEIGHBOR && in_corner != 2'd3)
            nb_mem[widx] <= {in_hasnb, in_nb};
      end
      corner_rd <= corner_mem[crd_addr];
      nb_rd <= nb_mem[crd_addr];
      nrm_rd <= normal_mem[face_ff];
      ctr_rd <= center_mem[face_ff];
   end
   assign crd_rd = corner_rd;

   logic away_we;
   assign away_we = (state_ff == S_SIGN);
   logic dot_pos;
   logic signed [67:0] acc;
   always_ff @(posedge clock) begin
      if (away_we) away_mem[face_ff] <= dot_pos;
      away_rd <= away_mem[away_addr];
   end

   // shared MAC: sum n[i]*(c[i]-l[i])
   sve_pkg::mac_cmd_type mcmd;
   always_comb begin
      mcmd = '0;
      mcmd.clear = (state_ff == S_CRD);
      if (state_ff == S_DOT) begin
         mcmd.enable = 1'b1;
         mcmd.a = nrm_rd[32*step_ff[1:0] +: 32];
         mcmd.b = 34'($signed(ctr_rd[32*step_ff[1:0] +: 32]))
                  - 34'(light_ff[step_ff[1:0]]);
      end
   end
   sve_mac u_mac (.clock(clock), .reset(reset), .cmd(mcmd), .acc(acc));
   assign dot_pos = !acc[67] && (acc != '0);

   // vertex selection
   logic [1:0] vc;
   logic vdark;
   logic [1:0] e_sel;
   logic [2:0] vk;
   logic [4:0] vrel;
   assign vrel = vtx_ff - 5'd6;
   always_comb begin
      vc = 2'd0; vdark = 1'b0; e_sel = 2'd0; vk = 3'd0;
      if (vtx_ff < 5'd3) begin
         vc = vtx_ff[1:0];
      end else if (vtx_ff < 5'd6) begin
         vc = 2'(3'd5 - vtx_ff[2:0]); vdark = 1'b1;
      end else begin
         vk = step_ff;
         e_sel = 2'(step_ff[1:0]);
         unique case (vrel[2:0])
            3'd0: begin vc = (e_sel == 2'd2) ? 2'd0 : 2'(e_sel + 2'd1); end
            3'd1: begin vc = e_sel; end
            3'd2: begin vc = e_sel; vdark = 1'b1; end
            3'd3: begin vc = (e_sel == 2'd2) ? 2'd0 : 2'(e_sel + 2'd1); end
            3'd4: begin vc = e_sel; vdark = 1'b1; end
            default: begin
               vc = (e_sel == 2'd2) ? 2'd0 : 2'(e_sel + 2'd1); vdark = 1'b1;
            end
         endcase
      end
   end
   logic signed [33:0] vout [3];
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         vout[j] = 34'($signed(crn_ff[vc][32*j +: 32]));
         if (vdark) vout[j] = (vout[j] <<< 1) - 34'(light_ff[j]);
      end
   end

   // any silhouette edge after the current one?
   logic more_edges;
   always_comb begin
      more_edges = 1'b0;
      if (vtx_ff < 5'd6) more_edges = |sil_ff;
      else if (step_ff == 3'd0) more_edges = |sil_ff[2:1];
      else if (step_ff == 3'd1) more_edges = sil_ff[2];
   end
   logic [2:0] next_edge;
   always_comb begin
      next_edge = 3'd3;
      for (int e = 2; e >= 0; e--)
         if (sil_ff[e] && (vtx_ff < 5'd6 || 3'(e) > step_ff)) next_edge = 3'(e);
   end

   logic last_v, out_fire;
   assign last_v = (vtx_ff == 5'd5 && !more_edges) || (vtx_ff == 5'd11 && !more_edges);
   assign out_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in = state_ff; face_in = face_ff; step_in = step_ff; vtx_in = vtx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && in_ok) begin
               face_in = fidx; step_in = 3'd0; vtx_in = 5'd0;
               if (in_mode == sve_pkg::MODE_CLASSIFY) state_in = S_CRD;
               else if (in_mode == sve_pkg::MODE_EMIT) state_in = S_AWAY;
            end
         end
         S_CRD: state_in = S_DOT;
         S_DOT: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd2) state_in = S_SIGN;
         end
         S_SIGN: state_in = S_IDLE;
         S_AWAY: begin
            step_in = 3'd3;
            if (step_ff == 3'd3) begin step_in = 3'd0; state_in = S_LRD; end
         end
         S_LRD: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin step_in = 3'd0; state_in = S_ARD; end
         end
         S_ARD: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) state_in = S_CHK;
         end
         S_CHK: begin state_in = S_OUT; step_in = 3'd0; vtx_in = 5'd0; end
         S_OUT: begin
            if (out_fire) begin
               if (last_v) state_in = S_IDLE;
               else if (vtx_ff == 5'd5 || vtx_ff == 5'd11) begin
                  vtx_in = 5'd6; step_in = next_edge;
               end else vtx_in = vtx_ff + 5'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   logic face_away_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= 3'd0;
         vtx_ff <= 5'd0;
         sil_ff <= 3'd0;
         face_away_ff <= 1'b0;
      end else begin
         // own away flag, addressed at step 3, lands in the first corner read cycle
         if (state_ff == S_LRD && step_ff == 3'd0) face_away_ff <= away_rd;
         // corners/neighbors land in the cycle after their address
         if (state_ff == S_LRD && step_ff != 3'd0) begin
            crn_ff[step_ff[1:0] - 2'd1] <= corner_rd;
            nbl_ff[step_ff[1:0] - 2'd1] <= nb_rd;
         end
         if (state_ff == S_ARD && step_ff != 3'd0) begin
            sil_ff[step_ff[1:0] - 2'd1] <= away_rd && nbl_ff[step_ff[1:0] - 2'd1][10]
               && ({22'd0, nbl_ff[step_ff[1:0] - 2'd1][9:0]} < 32'(FACES));
         end
         if (state_ff == S_CHK && face_away_ff) state_ff <= S_IDLE;
         else state_ff <= state_in;
         step_ff <= step_in;
         vtx_ff <= vtx_in;
      end
      face_ff <= face_in;
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {1'b0, ~vdark, vout[2], vout[1], vout[0]};
   assign rsp_tlast = last_v;

   // unused tap
   logic unused_ok;
   assign unused_ok = ^{crd_rd, vk, req_tdata[127:122]};

   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_last: assert property (@(posedge clock) disable iff (reset)
      out_fire && rsp_tlast |=> state_ff == S_IDLE) else $error("run not closed");
   a_vtx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> vtx_ff < 5'd12) else $error("vertex index");
endmodule
